// ===== rtl/blr_pkg.sv =====
// Shared types and constants of the Bresenham line rasteriser.
// Used by the controller, the datapath, the top level and the checker.
package blr_pkg;

   localparam int DEF_CANVAS_WIDTH  = 64;
   localparam int DEF_CANVAS_HEIGHT = 64;

   localparam int COORD_W = 6;
   localparam int VALUE_W = 8;
   localparam int ERR_W   = 9;            // holds -126 .. 126 with headroom
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 24;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } blr_state_type;

   typedef struct packed {
      logic load;                         // take a new line command
      logic step;                         // advance to the next point
   } blr_cmd_type;

   typedef struct packed {
      logic at_end;                       // current point is the end point
   } blr_status_type;

endpackage

// ===== rtl/blr_ctrl.sv =====
// Controller of the Bresenham line rasteriser: idle / tracing sequencer.
// Depends on blr_pkg; drives blr_datapath through command and status structs.
module blr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  blr_pkg::blr_status_type status,
   output blr_pkg::blr_cmd_type    cmd
);

   blr_pkg::blr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         blr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = blr_pkg::ST_RUN;
         end
         blr_pkg::ST_RUN: begin
            if (rsp_tready && status.at_end) state_in = blr_pkg::ST_IDLE;
         end
         default: state_in = blr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         blr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         blr_pkg::ST_RUN: begin
            rsp_tvalid = 1'b1;
            cmd.step   = rsp_tready && !status.at_end;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/blr_datapath.sv =====
// Datapath of the Bresenham line rasteriser: endpoint clamp, deltas and error term.
// Depends on blr_pkg; sequenced by blr_ctrl.
module blr_datapath #(
   parameter int CANVAS_WIDTH  = blr_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = blr_pkg::DEF_CANVAS_HEIGHT
) (
   input  logic                          clock,
   input  blr_pkg::blr_cmd_type          cmd,
   input  logic [blr_pkg::COORD_W-1:0]   x_start,
   input  logic [blr_pkg::COORD_W-1:0]   y_start,
   input  logic [blr_pkg::COORD_W-1:0]   x_end,
   input  logic [blr_pkg::COORD_W-1:0]   y_end,
   input  logic [blr_pkg::VALUE_W-1:0]   pixel_value,
   output logic [blr_pkg::COORD_W-1:0]   pixel_x,
   output logic [blr_pkg::COORD_W-1:0]   pixel_y,
   output logic [blr_pkg::VALUE_W-1:0]   write_value,
   output blr_pkg::blr_status_type       status
);

   localparam int CW = blr_pkg::COORD_W;
   localparam int EW = blr_pkg::ERR_W;
   localparam logic [CW-1:0] X_MAX = CW'(CANVAS_WIDTH - 1);
   localparam logic [CW-1:0] Y_MAX = CW'(CANVAS_HEIGHT - 1);

   logic [CW-1:0]                  cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]                  ex_ff, ex_in, ey_ff, ey_in;
   logic [CW-1:0]                  dx_ff, dx_in, dy_ff, dy_in;
   logic                           sx_ff, sx_in, sy_ff, sy_in;   // 1: count up
   logic signed [EW-1:0]           err_ff, err_in;
   logic [blr_pkg::VALUE_W-1:0]    val_ff, val_in;

   logic [CW-1:0]                  lx0, ly0, lx1, ly1;
   logic signed [EW:0]             e2, dx_s, dy_s;
   logic                           take_x, take_y;

   // saturate endpoints that lie beyond a smaller canvas
   always_comb begin
      lx0 = (x_start > X_MAX) ? X_MAX : x_start;
      ly0 = (y_start > Y_MAX) ? Y_MAX : y_start;
      lx1 = (x_end   > X_MAX) ? X_MAX : x_end;
      ly1 = (y_end   > Y_MAX) ? Y_MAX : y_end;
   end

   assign dx_s   = $signed({{(EW + 1 - CW){1'b0}}, dx_ff});
   assign dy_s   = $signed({{(EW + 1 - CW){1'b0}}, dy_ff});
   assign e2     = $signed({err_ff, 1'b0});
   assign take_x = e2 > -dy_s;
   assign take_y = e2 < dx_s;

   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      ex_in  = ex_ff;
      ey_in  = ey_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      err_in = err_ff;
      val_in = val_ff;
      if (cmd.load) begin
         cx_in  = lx0;
         cy_in  = ly0;
         ex_in  = lx1;
         ey_in  = ly1;
         dx_in  = (lx1 > lx0) ? (lx1 - lx0) : (lx0 - lx1);
         dy_in  = (ly1 > ly0) ? (ly1 - ly0) : (ly0 - ly1);
         sx_in  = lx0 < lx1;
         sy_in  = ly0 < ly1;
         err_in = $signed({{(EW - CW){1'b0}}, dx_in}) - $signed({{(EW - CW){1'b0}}, dy_in});
         val_in = pixel_value;
      end else if (cmd.step) begin
         // both axes may move in one step
         err_in = EW'(e2[EW:1] - (take_x ? dy_s : '0) + (take_y ? dx_s : '0));
         if (take_x) cx_in = sx_ff ? cx_ff + 1'b1 : cx_ff - 1'b1;
         if (take_y) cy_in = sy_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      err_ff <= err_in;
      val_ff <= val_in;
   end

   assign pixel_x       = cx_ff;
   assign pixel_y       = cy_ff;
   assign write_value   = val_ff;
   assign status.at_end = (cx_ff == ex_ff) && (cy_ff == ey_ff);

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasteriser, top level: a line command in, one beat per pixel out.
// Depends on blr_pkg, blr_ctrl and blr_datapath.
//
// One command beat carries two endpoints and a pixel byte; the block then sends one
// beat per point of the Bresenham line, start to end, in any octant, with tlast on the
// end point. A line has max(|dx|,|dy|)+1 points. The tracing loop steps one point per
// cycle while rsp_tready is high, and the command port is ready again in the cycle
// after the tlast beat is taken. Coordinates beyond a canvas smaller than 64 are
// saturated to the last column or row. Nothing is kept between commands.
module bresenham_line_rasterizer #(
   parameter int CANVAS_WIDTH  = blr_pkg::DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = blr_pkg::DEF_CANVAS_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18], pixel_value[31:24]
   input  logic [blr_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pixel_x[5:0], pixel_y[11:6], write_value[19:12], zero[23:20]
   output logic [blr_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast   // last_pixel
);

   blr_pkg::blr_cmd_type          cmd;
   blr_pkg::blr_status_type       status;
   logic [blr_pkg::COORD_W-1:0]   pixel_x, pixel_y;
   logic [blr_pkg::VALUE_W-1:0]   write_value;

   blr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   blr_datapath #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .x_start     (req_tdata[5:0]),
      .y_start     (req_tdata[11:6]),
      .x_end       (req_tdata[17:12]),
      .y_end       (req_tdata[23:18]),
      .pixel_value (req_tdata[31:24]),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .write_value (write_value),
      .status      (status)
   );

   assign rsp_tdata = {4'b0000, write_value, pixel_y, pixel_x};
   assign rsp_tlast = status.at_end;

endmodule

// ===== rtl/blr_checker.sv =====
// Port-level checks of the Bresenham line rasteriser, bound to the top level.
// Depends on blr_pkg for the bus widths.
module blr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [blr_pkg::RSP_W-1:0]   rsp_tdata,
   input logic                        rsp_tlast
);

   // never takes a command while a line is being sent
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("command port ready while pixels pending");

   // the first pixel follows the command beat at once
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no pixel after command beat");

   // a line keeps going until its tlast beat
   a_continue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("line stopped before its last pixel");

   // after the last beat the block is idle again
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after last pixel");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled pixel beat changed");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb_top.sv =====
// Self-checking bench for the Bresenham line rasteriser: random line commands in,
// pixel beats checked against a local line tracer. Needs blr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_RANDOM_LINES = 448;
   localparam int IDLE_LIMIT       = 4000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int MAX_LINE_PIXELS  = 64;

   typedef struct packed {
      logic [blr_pkg::COORD_W-1:0] x;
      logic [blr_pkg::COORD_W-1:0] y;
      logic [blr_pkg::VALUE_W-1:0] value;
      logic                        last;
   } pixel_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [blr_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [blr_pkg::RSP_W-1:0] rsp_tdata;
   logic                      rsp_tlast;

   logic [blr_pkg::REQ_W-1:0] line_cmds[$];
   pixel_write_type           pixels_due[$];

   bit req_fire;
   bit rsp_fire;
   int req_gap_left;
   int rsp_stall_left;
   int req_calm_left;
   int rsp_calm_left;
   int idle_cycles;
   int error_count;
   int lines_traced;
   int single_point_lines;
   int pixels_checked;

   bresenham_line_rasterizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, and calm stretches with none at all.
   function automatic int draw_idle_len(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_coord(input logic [blr_pkg::COORD_W-1:0] raw,
                                      input int limit);
      int v;
      v = int'(raw);
      if (v > limit - 1) v = limit - 1;
      return v;
   endfunction

   // Trace one line command and queue every pixel write it should produce.
   function automatic void trace_line_pixels(input logic [blr_pkg::REQ_W-1:0] cmd);
      int cx, cy, ex, ey, dx, dy, sx, sy, err, e2, n;
      bit done;
      pixel_write_type px;
      cx = clamp_coord(cmd[5:0],   blr_pkg::DEF_CANVAS_WIDTH);
      cy = clamp_coord(cmd[11:6],  blr_pkg::DEF_CANVAS_HEIGHT);
      ex = clamp_coord(cmd[17:12], blr_pkg::DEF_CANVAS_WIDTH);
      ey = clamp_coord(cmd[23:18], blr_pkg::DEF_CANVAS_HEIGHT);
      dx = (ex > cx) ? ex - cx : cx - ex;
      dy = (ey > cy) ? ey - cy : cy - ey;
      sx = (cx < ex) ? 1 : -1;
      sy = (cy < ey) ? 1 : -1;
      err = dx - dy;
      n = 0;
      done = 1'b0;
      while (!done && n < MAX_LINE_PIXELS) begin
         done = (cx == ex) && (cy == ey);
         px.x     = cx[blr_pkg::COORD_W-1:0];
         px.y     = cy[blr_pkg::COORD_W-1:0];
         px.value = cmd[31:24];
         px.last  = done;
         pixels_due.push_back(px);
         n++;
         if (!done) begin
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               cx += sx;
            end
            if (e2 < dx) begin
               err += dx;
               cy += sy;
            end
         end
      end
      lines_traced++;
      if (n == 1) single_point_lines++;
   endfunction

   task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                           input int value);
      line_cmds.push_back({value[7:0], ye[5:0], xe[5:0], ys[5:0], xs[5:0]});
   endtask

   function automatic int near_coord(input int base);
      int t;
      t = base + int'($urandom_range(0, 6)) - 3;
      if (t < 0) t = 0;
      if (t > 63) t = 63;
      return t;
   endfunction

   // Command driver: one beat per queued line, random gaps between beats.
   always @(negedge clock) begin
      logic                      valid_n;
      logic [blr_pkg::REQ_W-1:0] data_n;
      valid_n = req_tvalid;
      data_n  = req_tdata;
      if (reset) begin
         valid_n = 1'b0;
      end else if (req_fire || !req_tvalid) begin
         valid_n = 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
         end else if (line_cmds.size() > 0) begin
            data_n  = line_cmds.pop_front();
            valid_n = 1'b1;
            req_gap_left = draw_idle_len(req_calm_left);
         end
      end
      req_tvalid <= valid_n;
      req_tdata  <= data_n;
   end

   // Pixel sink: back-pressure at random.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left = draw_idle_len(rsp_calm_left);
      end
   end

   // Monitor: predict on command beats, check pixel beats, watch for a hang.
   always @(posedge clock) begin
      pixel_write_type exp_px;
      pixel_write_type got_px;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire) trace_line_pixels(req_tdata);
      if (rsp_fire) begin
         got_px.x     = rsp_tdata[5:0];
         got_px.y     = rsp_tdata[11:6];
         got_px.value = rsp_tdata[19:12];
         got_px.last  = rsp_tlast;
         pixels_checked++;
         if (pixels_due.size() == 0) begin
            error_count++;
            $display("%0t: expected no pixel beat, got x=%0d y=%0d value=%02h last=%0b",
                     $realtime, got_px.x, got_px.y, got_px.value, got_px.last);
         end else begin
            exp_px = pixels_due.pop_front();
            if (got_px !== exp_px) begin
               error_count++;
               $display("%0t: pixel mismatch: expected x=%0d y=%0d value=%02h last=%0b,",
                        $realtime, exp_px.x, exp_px.y, exp_px.value, exp_px.last);
               $display("   got x=%0d y=%0d value=%02h last=%0b",
                        got_px.x, got_px.y, got_px.value, got_px.last);
            end
         end
      end
      if (reset || req_fire || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d pixels still due", $realtime,
                     IDLE_LIMIT, pixels_due.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int xs, ys, xe, ye, kind;

      // single points, both corners
      add_line(0, 0, 0, 0, 8'h00);
      add_line(63, 63, 63, 63, 8'hFF);
      // full diagonals, both directions
      add_line(0, 0, 63, 63, 8'hAA);
      add_line(63, 63, 0, 0, 8'h55);
      add_line(0, 63, 63, 0, 8'h0F);
      add_line(63, 0, 0, 63, 8'hF0);
      // full-width horizontal and full-height vertical
      add_line(0, 5, 63, 5, 8'h01);
      add_line(63, 40, 0, 40, 8'h80);
      add_line(7, 0, 7, 63, 8'h7E);
      add_line(50, 63, 50, 0, 8'h81);
      // one of each octant
      add_line(10, 10, 40, 20, 8'h11);
      add_line(10, 10, 20, 40, 8'h22);
      add_line(40, 20, 10, 10, 8'h33);
      add_line(20, 40, 10, 10, 8'h44);
      add_line(10, 40, 40, 30, 8'h66);
      add_line(10, 40, 20, 10, 8'h77);
      add_line(40, 30, 10, 40, 8'h99);
      add_line(20, 10, 10, 40, 8'hBB);
      // error-term ties and single steps
      add_line(0, 0, 2, 1, 8'hCC);
      add_line(0, 0, 1, 2, 8'hDD);
      add_line(5, 5, 6, 5, 8'hEE);
      add_line(5, 5, 6, 6, 8'h3C);

      for (int i = 0; i < NUM_RANDOM_LINES; i++) begin
         xs = $urandom_range(0, 63);
         ys = $urandom_range(0, 63);
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            xe = $urandom_range(0, 63);
            ye = $urandom_range(0, 63);
         end else if (kind < 80) begin
            xe = near_coord(xs);
            ye = near_coord(ys);
         end else if (kind < 87) begin
            xe = $urandom_range(0, 63);
            ye = ys;
         end else if (kind < 94) begin
            xe = xs;
            ye = $urandom_range(0, 63);
         end else begin
            xe = xs;
            ye = ys;
         end
         add_line(xs, ys, xe, ye, $urandom_range(0, 255));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Traced %0d line commands (%0d single points), %0d pixel beats checked.",
               lines_traced, single_point_lines, pixels_checked);
      $display("Octants, axis lines, diagonals and random back-pressure on both ports.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d errors", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
